FILE: src/lapet_pkg.sv
`default_nettype none
package lapet_pkg;

  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  localparam int FW_W = 12;
  localparam int FH_W = 16;
  localparam int TH_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;
  localparam logic [TH_W-1:0] TH_RESET = 8'd26;

  localparam logic [FW_W-1:0] FW_MIN = 12'd3;
  localparam logic [FH_W-1:0] FH_MIN = 16'd3;

  localparam int DEF_MAX_WIDTH = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_EDGE_THRESHOLD
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
  } lapet_win_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_end;
  } lapet_res_t;

endpackage
`default_nettype wire

FILE: src/lapet_stream_if.sv
`default_nettype none
interface lapet_in_if;
  logic                       valid;
  logic                       ready;
  logic [lapet_pkg::PIX_W-1:0] gray_pixel;
  logic                       drain;

  modport source(output valid, output gray_pixel, output drain, input ready);
  modport sink(input valid, input gray_pixel, input drain, output ready);
endinterface

interface lapet_out_if;
  logic                       valid;
  logic                       ready;
  logic [lapet_pkg::PIX_W-1:0] out_pixel;
  logic                       frame_end;

  modport source(output valid, output out_pixel, output frame_end, input ready);
  modport sink(input valid, input out_pixel, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: src/lapet_line_buf.sv
`default_nettype none
module lapet_line_buf #(
  parameter int MAX_WIDTH = lapet_pkg::DEF_MAX_WIDTH,
  localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [COL_BITS-1:0]         waddr,
  input  wire logic [lapet_pkg::PIX_W-1:0] wdata_above,
  input  wire logic [lapet_pkg::PIX_W-1:0] wdata_two_above,
  input  wire logic [COL_BITS-1:0]         raddr,
  output logic      [lapet_pkg::PIX_W-1:0] rd_centre,
  output logic      [lapet_pkg::PIX_W-1:0] rd_right,
  output logic      [lapet_pkg::PIX_W-1:0] rd_up
);
  import lapet_pkg::*;

  logic [PIX_W-1:0] line_above     [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_above [MAX_WIDTH];
  logic [COL_BITS-1:0] raddr_right;

  assign raddr_right = raddr + COL_BITS'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      line_above[waddr]     <= wdata_above;
      line_two_above[waddr] <= wdata_two_above;
    end
    rd_centre <= line_above[raddr];
    rd_right  <= line_above[raddr_right];
    rd_up     <= line_two_above[raddr];
  end

endmodule
`default_nettype wire

FILE: src/lapet_kernel.sv
`default_nettype none
module lapet_kernel (
  input  wire lapet_pkg::lapet_win_t       win,
  input  wire logic [lapet_pkg::TH_W-1:0]  threshold,
  output logic      [lapet_pkg::PIX_W-1:0] edge_pixel
);
  import lapet_pkg::*;

  localparam int RESP_W = PIX_W + 3;

  logic [RESP_W-1:0] resp;
  logic [PIX_W-1:0]  clamped;
  logic              negative;
  logic              overflow;

  always_comb begin
    resp = {1'b0, win.centre, 2'b00}
         - {3'b000, win.up} - {3'b000, win.down}
         - {3'b000, win.left} - {3'b000, win.right};
    negative = resp[RESP_W-1];
    overflow = !negative && (resp[RESP_W-2:PIX_W] != '0);
    if (negative) begin
      clamped = '0;
    end else if (overflow) begin
      clamped = PIX_MAX;
    end else begin
      clamped = resp[PIX_W-1:0];
    end
    edge_pixel = (TH_W'(clamped) > threshold) ? PIX_MAX : '0;
  end

endmodule
`default_nettype wire

FILE: src/lapet_out_skid.sv
`default_nettype none
module lapet_out_skid (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lapet_pkg::lapet_res_t push_data,
  output logic                       full,
  lapet_out_if.source                pix_out
);
  import lapet_pkg::*;

  logic       main_valid;
  logic       skid_valid;
  lapet_res_t main_data;
  lapet_res_t skid_data;
  logic       pop;

  assign pop = main_valid && pix_out.ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign pix_out.valid     = main_valid;
  assign pix_out.out_pixel = main_data.out_pixel;
  assign pix_out.frame_end = main_data.frame_end;

endmodule
`default_nettype wire

FILE: src/laplacian_edge_threshold.sv
`default_nettype none
// Four-neighbour Laplacian edge detector on a raster stream of gray pixels. One pixel
// is taken per clock with ready high; the result for a pixel comes out when the pixel
// below it arrives, one row later, and row 0 gives no results. After the last row the
// user sends one drain transfer per column to flush the last row; frame_end marks its
// last pixel. Interior pixels give 255 when the clamped response exceeds edge_threshold
// and 0 otherwise; border pixels pass through. Two line buffers of MAX_WIDTH entries
// have one write port and registered read ports addressed one transfer ahead, so ready
// drops for one cycle after reset and after every configuration write while the read
// data refreshes. A two-entry output stage lets input continue while a result waits.
module laplacian_edge_threshold #(
  parameter int MAX_WIDTH = lapet_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lapet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lapet_pkg::CFG_DATA_W-1:0] cfg_data,
  lapet_in_if.sink                              pix_in,
  lapet_out_if.source                           pix_out
);
  import lapet_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int MW_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int WB       = (FW_W > MW_BITS) ? FW_W : MW_BITS;

  logic [FW_W-1:0]     frame_width;
  logic [FH_W-1:0]     frame_height;
  logic [TH_W-1:0]     edge_threshold;
  logic [COL_BITS-1:0] column_count;
  logic [COL_BITS-1:0] column_count_next;
  logic [FH_W-1:0]     row_count;
  logic [FH_W-1:0]     row_count_next;
  logic [PIX_W-1:0]    left_pixel;
  logic                stale;

  logic [WB-1:0]       w_eff;
  logic [WB-1:0]       w_last;
  logic [FH_W-1:0]     h_eff;
  logic [COL_BITS-1:0] col;
  logic [COL_BITS-1:0] col_inc;
  logic [COL_BITS-1:0] raddr;
  logic                last_col;
  logic                drain_phase;
  logic                accept;
  logic                advance;
  logic                pix_step;
  logic                interior;
  logic                skid_full;

  logic [PIX_W-1:0]    rd_centre;
  logic [PIX_W-1:0]    rd_right;
  logic [PIX_W-1:0]    rd_up;
  logic [PIX_W-1:0]    edge_pixel;
  lapet_win_t          win;
  lapet_res_t          res;
  logic                push;

  function automatic logic [COL_BITS-1:0] clamp_col(logic [COL_BITS-1:0] c,
                                                    logic [WB-1:0] last);
    logic [WB-1:0] c_ext;
    c_ext = WB'(c);
    clamp_col = (c_ext >= last) ? last[COL_BITS-1:0] : c;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FW_RESET;
      frame_height   <= FH_RESET;
      edge_threshold <= TH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[FH_W-1:0];
        CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data[TH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < FW_MIN) begin
      w_eff = WB'(FW_MIN);
    end else if (WB'(frame_width) > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(frame_width);
    end
    w_last = w_eff - WB'(1);
    h_eff  = (frame_height < FH_MIN) ? FH_MIN : frame_height;
  end

  assign col         = clamp_col(column_count, w_last);
  assign col_inc     = col + COL_BITS'(1);
  assign last_col    = (WB'(col) == w_last);
  assign drain_phase = (row_count >= h_eff);

  assign pix_in.ready = !stale && !skid_full;
  assign accept   = pix_in.valid && pix_in.ready;
  assign advance  = accept && (drain_phase || !pix_in.drain);
  assign pix_step = accept && !drain_phase && !pix_in.drain;
  assign interior = (row_count >= FH_W'(2)) && (col != '0) && !last_col;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (advance) begin
      column_count_next = last_col ? '0 : col_inc;
      if (last_col) begin
        row_count_next = drain_phase ? '0 : row_count + FH_W'(1);
      end
    end
  end

  assign raddr = clamp_col(column_count_next, w_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
      stale        <= 1'b1;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      stale        <= cfg_we;
      if (pix_step) begin
        left_pixel <= rd_centre;
      end
    end
  end

  lapet_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk            (clk),
    .we             (pix_step),
    .waddr          (col),
    .wdata_above    (pix_in.gray_pixel),
    .wdata_two_above(rd_centre),
    .raddr          (raddr),
    .rd_centre      (rd_centre),
    .rd_right       (rd_right),
    .rd_up          (rd_up)
  );

  always_comb begin
    win.centre = rd_centre;
    win.up     = rd_up;
    win.down   = pix_in.gray_pixel;
    win.left   = left_pixel;
    win.right  = rd_right;
  end

  lapet_kernel u_kernel (
    .win       (win),
    .threshold (edge_threshold),
    .edge_pixel(edge_pixel)
  );

  always_comb begin
    res.out_pixel = (!drain_phase && interior) ? edge_pixel : rd_centre;
    res.frame_end = drain_phase && last_col;
    push = drain_phase ? accept : (pix_step && (row_count != '0));
  end

  lapet_out_skid u_out_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(res),
    .full     (skid_full),
    .pix_out  (pix_out)
  );

endmodule
`default_nettype wire

FILE: src/lapet_checker.sv
`default_nettype none
module lapet_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        cfg_we,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lapet_pkg::PIX_W-1:0] out_pixel,
  input wire logic                        frame_end
);

  // no result without a transfer in or a result already pending
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (!$past(in_valid && in_ready) && !$past(out_valid)) |-> !out_valid)
    else $error("result appeared without a preceding transfer");

  // read data refresh after a configuration write
  a_cfg_gap: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input ready right after configuration write");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_pixel) && $stable(frame_end)))
    else $error("output payload changed while stalled");

endmodule

bind laplacian_edge_threshold lapet_checker u_lapet_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_we   (cfg_we),
  .in_valid (pix_in.valid),
  .in_ready (pix_in.ready),
  .out_valid(pix_out.valid),
  .out_ready(pix_out.ready),
  .out_pixel(pix_out.out_pixel),
  .frame_end(pix_out.frame_end)
);
`default_nettype wire

FILE: tb/lapet_edge_checker.sv
`timescale 1ns / 100ps
module lapet_edge_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lapet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lapet_pkg::CFG_DATA_W-1:0] cfg_data,
  lapet_in_if                                   pix_in,
  lapet_out_if                                  pix_out,
  output int                                    pending,
  output int                                    mismatches
);
  import lapet_pkg::*;

  logic [PIX_W-1:0]   row_above     [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]   row_two_above [DEF_MAX_WIDTH];
  logic [3*PIX_W-1:0] window;
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  logic [FW_W-1:0]    width_reg;
  logic [FH_W-1:0]    height_reg;
  logic [TH_W-1:0]    thresh_reg;
  lapet_res_t         expected_pixels[$];
  lapet_res_t         want;
  int                 errs = 0;

  function automatic void predict_edge_pixel(input logic [PIX_W-1:0] pix, input logic drn);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic        last;
    logic [PIX_W-1:0] centre;
    int          resp;
    lapet_res_t  res;
    w = (width_reg < FW_MIN) ? FW_MIN : width_reg;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    h = (height_reg < FH_MIN) ? FH_MIN : height_reg;
    c = (col_cnt >= w - 1) ? w - 1 : col_cnt;
    last = (c == w - 1);

    // flush of the last row, all border
    if (row_cnt >= h) begin
      res.out_pixel = row_above[c];
      res.frame_end = last;
      expected_pixels.push_back(res);
      if (last) begin
        col_cnt = 0;
        row_cnt = 0;
      end else begin
        col_cnt = c + 1;
      end
      return;
    end
    if (drn) return;

    centre = row_above[c];
    window = {window[2*PIX_W-1:0], centre};
    if (row_cnt >= 1) begin
      res.frame_end = 1'b0;
      if (row_cnt >= 2 && c >= 1 && c < w - 1) begin
        resp = 4 * int'(centre) - int'(row_two_above[c]) - int'(pix)
               - int'(window[2*PIX_W-1:PIX_W]) - int'(row_above[c+1]);
        if (resp < 0) resp = 0;
        if (resp > int'(PIX_MAX)) resp = int'(PIX_MAX);
        res.out_pixel = (resp > int'(thresh_reg)) ? PIX_MAX : '0;
      end else begin
        res.out_pixel = centre;
      end
      expected_pixels.push_back(res);
    end
    row_two_above[c] = centre;
    row_above[c] = pix;
    if (last) begin
      col_cnt = 0;
      row_cnt = row_cnt + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      window = '0;
      col_cnt = 0;
      row_cnt = 0;
      width_reg = FW_RESET;
      height_reg = FH_RESET;
      thresh_reg = TH_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:    width_reg = cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT:   height_reg = cfg_data[FH_W-1:0];
          CFG_EDGE_THRESHOLD: thresh_reg = cfg_data[TH_W-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) predict_edge_pixel(pix_in.gray_pixel, pix_in.drain);
      if (pix_out.valid && pix_out.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got out_pixel %0d frame_end %0b",
                   $time, pix_out.out_pixel, pix_out.frame_end);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_out.out_pixel !== want.out_pixel) begin
            $display("%0t: out_pixel expected %0d got %0d",
                     $time, want.out_pixel, pix_out.out_pixel);
            errs++;
          end
          if (pix_out.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b got %0b",
                     $time, want.frame_end, pix_out.frame_end);
            errs++;
          end
        end
      end
    end
    pending <= expected_pixels.size();
    mismatches <= errs;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import lapet_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    mismatches;
  int                    cycle_count = 0;
  int                    src_idle_pct = 0;
  int                    sink_idle_pct = 0;
  int                    sent_items = 0;
  int unsigned           fw;
  int unsigned           fh;

  lapet_in_if  in_ch();
  lapet_out_if out_ch();

  laplacian_edge_threshold u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (in_ch),
    .pix_out   (out_ch)
  );

  lapet_edge_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_in     (in_ch),
    .pix_out    (out_ch),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_w();
    if (fw < FW_MIN) return FW_MIN;
    if (fw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return fw;
  endfunction

  function automatic int unsigned eff_h();
    return (fh < FH_MIN) ? FH_MIN : fh;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(3))
      0: return '0;
      1: return PIX_MAX;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        src_idle_pct = 33;
        sink_idle_pct = 84;
      end
      1: begin
        src_idle_pct = 84;
        sink_idle_pct = 33;
      end
      default: begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_item(input logic [PIX_W-1:0] pix, input logic drn);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.gray_pixel <= pix;
    in_ch.drain <= drn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_FRAME_WIDTH:  fw = val;
      CFG_FRAME_HEIGHT: fh = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold input until every result is out, then let the pipeline settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pixel transfers with an occasional early drain that must be ignored
  task automatic send_pixels(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_item(rand_pixel(), 1'b1);
      send_item(rand_pixel(), 1'b0);
      sent_items++;
    end
  endtask

  // flush of the last row; some carry a pixel, which acts as drain
  task automatic send_drain(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(rand_pixel(), ($urandom_range(4) != 0));
      sent_items++;
    end
  endtask

  task automatic send_frame();
    send_pixels(eff_w() * eff_h());
    send_drain(eff_w());
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.gray_pixel <= '0;
    in_ch.drain <= 1'b0;
    fw = FW_RESET;
    fh = FH_RESET;
    set_idle(0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bright dot on black, strongest response against a high threshold
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_EDGE_THRESHOLD, 254);
    for (int i = 0; i < 9; i++) begin
      send_item((i == 4) ? PIX_MAX : PIX_W'(0), 1'b0);
      if (i == 1) send_item(8'h5a, 1'b1);
    end
    send_item('0, 1'b1);
    send_item(8'haa, 1'b0);
    send_item(PIX_MAX, 1'b1);

    // dark dot on white, out-of-range sizes, zero threshold
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    write_reg(CFG_EDGE_THRESHOLD, 0);
    for (int i = 0; i < 9; i++) send_item((i == 4) ? PIX_W'(0) : PIX_MAX, 1'b0);
    send_item('0, 1'b1);
    send_item(8'h55, 1'b1);
    send_item(PIX_MAX, 1'b1);

    // width above the maximum, narrowed in the middle of the first row
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 4095);
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_EDGE_THRESHOLD, $urandom_range(255));
    send_pixels(40);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 3);
    send_pixels(7);
    send_drain(3);

    // tallest frame cut short by a height change mid-frame
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 65535);
    write_reg(CFG_EDGE_THRESHOLD, 255);
    send_pixels(9);
    wait_idle();
    write_reg(CFG_EDGE_THRESHOLD, $urandom_range(255));
    send_pixels(9);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 3);
    send_drain(3);

    // narrower rows from the middle of a frame on
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 8);
    write_reg(CFG_FRAME_HEIGHT, 5);
    send_pixels(16);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 4);
    send_pixels(12);
    send_drain(4);

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      set_idle(sent_items * 3 / RANDOM_ITEMS);
      if (sent_items == 0 || $urandom_range(1) == 1) begin
        wait_idle();
        case ($urandom_range(9))
          0: write_reg(CFG_FRAME_WIDTH, $urandom_range(2));
          1: write_reg(CFG_FRAME_WIDTH, $urandom_range(64, 13));
          default: write_reg(CFG_FRAME_WIDTH, $urandom_range(12, 3));
        endcase
        if ($urandom_range(7) == 0) write_reg(CFG_FRAME_HEIGHT, $urandom_range(2));
        else write_reg(CFG_FRAME_HEIGHT, $urandom_range(8, 3));
        case ($urandom_range(5))
          0: write_reg(CFG_EDGE_THRESHOLD, 0);
          1: write_reg(CFG_EDGE_THRESHOLD, 255);
          default: write_reg(CFG_EDGE_THRESHOLD, $urandom_range(255));
        endcase
      end
      send_frame();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
